// ===== hw/rtl/epm_pkg.sv =====
// Shared constants, types and codes of the eta-phi pair matcher.
`timescale 1ns / 1ps
package epm_pkg;

    localparam int MAX_TRACKS   = 32;
    localparam int MAX_SEGMENTS = 32;
    localparam int QUERY_FACTOR = 3;

    localparam int CHAIN_DEPTH = (MAX_TRACKS > MAX_SEGMENTS) ? MAX_TRACKS : MAX_SEGMENTS;
    localparam int IDX_W       = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam int CNT_W       = $clog2(CHAIN_DEPTH + 1);
    localparam int STEP_W      = $clog2(2 * CHAIN_DEPTH + 1);

    localparam int ETA_W     = 16;
    localparam int PHI_W     = 15;
    localparam int CUT_W     = 15;
    localparam int KIND_W    = 2;
    localparam int OUT_IDX_W = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CUT_W-1:0] CUT_RESET = 15'd3277;
    localparam int PI_Q     = 12868;
    localparam int TWO_PI_Q = 25736;

    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEGMENT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TS_CUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SS_CUT = 1'd1;

    typedef struct packed {
        logic signed [ETA_W-1:0] eta;
        logic signed [PHI_W-1:0] phi;
    } pt_t;

    typedef struct packed {
        logic             valid;
        logic             seg;
        logic             done;
        logic [IDX_W-1:0] idx;
    } tok_t;

    typedef struct packed {
        logic             valid;
        logic             seg;
        logic             done;
        logic [IDX_W-1:0] idx;
        logic             msg;
    } res_t;

endpackage

// ===== hw/rtl/epm_cell.sv =====
// One storage cell of the point ring: holds a single eta-phi point.
`timescale 1ns / 1ps
module epm_cell
    import epm_pkg::*;
(
    input  logic clk,
    input  logic shift,
    input  pt_t  nbr_pt,
    input  logic wr,
    input  pt_t  wr_pt,
    output pt_t  pt
);

    pt_t pt_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            pt_reg <= nbr_pt;
        end
        else if (wr)
        begin
            pt_reg <= wr_pt;
        end
    end

    assign pt = pt_reg;

endmodule

// ===== hw/rtl/epm_chain.sv =====
// Ring of point cells that rotates one place per shift towards the head cell.
`timescale 1ns / 1ps
module epm_chain
    import epm_pkg::*;
(
    input  logic             clk,
    input  logic             shift,
    input  logic             wr,
    input  logic [IDX_W-1:0] wr_idx,
    input  pt_t              wr_pt,
    output pt_t              head
);

    pt_t cell_pt [CHAIN_DEPTH];

    for (genvar k = 0; k < CHAIN_DEPTH; k++)
    begin : g_cell
        localparam int NXT = (k + 1) % CHAIN_DEPTH;

        epm_cell u_cell (
            .clk    (clk),
            .shift  (shift),
            .nbr_pt (cell_pt[NXT]),
            .wr     (wr && (wr_idx == IDX_W'(k))),
            .wr_pt  (wr_pt),
            .pt     (cell_pt[k])
        );
    end

    assign head = cell_pt[0];

endmodule

// ===== hw/rtl/epm_dist.sv =====
// Distance pipeline: differences with phi wrap, squares, and the two cut tests.
`timescale 1ns / 1ps
module epm_dist
    import epm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  tok_t             tok,
    input  pt_t              pt_a,
    input  pt_t              pt_b,
    input  logic [CUT_W-1:0] ts_cut,
    input  logic [CUT_W-1:0] ss_cut,
    output res_t             res
);

    localparam int DE_W  = ETA_W + 1;
    localparam int DPR_W = PHI_W + 2;
    localparam int DE2_W = 2 * DE_W;
    localparam int DP2_W = 2 * PHI_W;
    localparam int D2_W  = DE2_W + 1;
    localparam int C2_W  = 2 * CUT_W;
    localparam int Q_W   = CUT_W + $clog2(QUERY_FACTOR + 1);
    localparam int Q2_W  = 2 * Q_W;
    localparam int CMP_W = (D2_W > Q2_W) ? D2_W : Q2_W;

    localparam logic signed [DPR_W-1:0] PI_S     = DPR_W'(PI_Q);
    localparam logic signed [DPR_W-1:0] NEG_PI_S = -DPR_W'(PI_Q);
    localparam logic signed [DPR_W-1:0] TWO_PI_S = DPR_W'(TWO_PI_Q);

    logic signed [DE_W-1:0]  de_c;
    logic signed [DPR_W-1:0] dpr_c;
    logic signed [DPR_W-1:0] dpw_c;

    tok_t                    s1_tok_reg;
    logic signed [DE_W-1:0]  s1_de_reg;
    logic signed [PHI_W-1:0] s1_dp_reg;

    tok_t                    s2_tok_reg;
    logic [DE2_W-1:0]        s2_de2_reg;
    logic [DP2_W-1:0]        s2_dp2_reg;

    logic [Q_W-1:0]          ts_q_reg;
    logic [Q_W-1:0]          ss_q_reg;
    logic [C2_W-1:0]         ts_c2_reg;
    logic [C2_W-1:0]         ss_c2_reg;
    logic [Q2_W-1:0]         ts_q2_reg;
    logic [Q2_W-1:0]         ss_q2_reg;

    logic [D2_W-1:0]         d2_c;
    logic [CMP_W-1:0]        c2_c;
    logic [CMP_W-1:0]        q2_c;

    assign de_c  = {pt_a.eta[ETA_W-1], pt_a.eta} - {pt_b.eta[ETA_W-1], pt_b.eta};
    assign dpr_c = {{2{pt_a.phi[PHI_W-1]}}, pt_a.phi} - {{2{pt_b.phi[PHI_W-1]}}, pt_b.phi};

    always_comb
    begin
        if (dpr_c > PI_S)
        begin
            dpw_c = dpr_c - TWO_PI_S;
        end
        else if (dpr_c < NEG_PI_S)
        begin
            dpw_c = dpr_c + TWO_PI_S;
        end
        else
        begin
            dpw_c = dpr_c;
        end
    end

    // The cut squares follow the configuration registers continuously.
    always_ff @(posedge clk)
    begin
        ts_q_reg  <= Q_W'(QUERY_FACTOR) * Q_W'(ts_cut);
        ss_q_reg  <= Q_W'(QUERY_FACTOR) * Q_W'(ss_cut);
        ts_c2_reg <= C2_W'(ts_cut) * C2_W'(ts_cut);
        ss_c2_reg <= C2_W'(ss_cut) * C2_W'(ss_cut);
        ts_q2_reg <= Q2_W'(ts_q_reg) * Q2_W'(ts_q_reg);
        ss_q2_reg <= Q2_W'(ss_q_reg) * Q2_W'(ss_q_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tok_reg <= '0;
            s2_tok_reg <= '0;
        end
        else if (adv)
        begin
            s1_tok_reg <= tok;
            s2_tok_reg <= s1_tok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_de_reg  <= de_c;
            s1_dp_reg  <= dpw_c[PHI_W-1:0];
            s2_de2_reg <= $unsigned(DE2_W'(s1_de_reg) * DE2_W'(s1_de_reg));
            s2_dp2_reg <= $unsigned(DP2_W'(s1_dp_reg) * DP2_W'(s1_dp_reg));
        end
    end

    assign d2_c = D2_W'(s2_de2_reg) + D2_W'(s2_dp2_reg);
    assign c2_c = s2_tok_reg.seg ? CMP_W'(ss_c2_reg) : CMP_W'(ts_c2_reg);
    assign q2_c = s2_tok_reg.seg ? CMP_W'(ss_q2_reg) : CMP_W'(ts_q2_reg);

    always_comb
    begin
        res.valid = s2_tok_reg.valid && (CMP_W'(d2_c) < q2_c);
        res.seg   = s2_tok_reg.seg;
        res.done  = s2_tok_reg.done;
        res.idx   = s2_tok_reg.idx;
        res.msg   = CMP_W'(d2_c) < c2_c;
    end

endmodule

// ===== hw/rtl/eta_phi_delta_r_pair_matcher_core.sv =====
// Top level of the eta-phi pair matcher: control, point rings and result output.
//
// Input requests carry kind, eta and phi and are taken when in_valid is high and
// in_stall is low. A clear or track request gives no result. A segment request,
// when tracks are stored and the segment fits, starts a sweep: the track ring and
// then the segment ring each rotate once past one shared distance unit, one
// stored point per cycle while no output waits on out_stall; in_stall is high
// while the sweep runs. Output requests leave through a register on out_valid;
// the final request caused by a segment carries last. A candidate is held back
// one place so that last can be set on it when the sweep ends. While out_stall
// is high the whole sweep freezes, so no request is lost, and the next input
// request may be taken while the final result of the previous one still waits.
// The freeze holds only while a result waits in the output register.
// Configuration writes on cfg_write are expected only while the block is idle;
// the cut tests see them through registers. Reset clears the counts, returns
// both cuts to 0.8 and empties the output; the stored points are not cleared.
`timescale 1ns / 1ps
module eta_phi_delta_r_pair_matcher_core
    import epm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [KIND_W-1:0]       kind,
    input  logic signed [ETA_W-1:0] eta,
    input  logic signed [PHI_W-1:0] phi,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    pair_kind,
    output logic [OUT_IDX_W-1:0]    first_index,
    output logic [OUT_IDX_W-1:0]    second_index,
    output logic                    message_edge,
    output logic                    last,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CUT_W-1:0]        cfg_data
);

    logic              busy_reg;
    logic              issue_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  trk_cnt_reg;
    logic [CNT_W-1:0]  seg_cnt_reg;
    logic [CUT_W-1:0]  ts_cut_reg;
    logic [CUT_W-1:0]  ss_cut_reg;

    logic [IDX_W-1:0]  seg_idx_reg;
    pt_t               qry_reg;

    logic              pend_valid_reg;
    logic              pend_seg_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic              pend_msg_reg;

    logic              out_valid_reg;
    logic              out_kind_reg;
    logic [IDX_W-1:0]  out_first_reg;
    logic [IDX_W-1:0]  out_second_reg;
    logic              out_msg_reg;
    logic              out_last_reg;

    logic              adv;
    logic              accept;
    logic              trk_ok;
    logic              seg_ok;
    logic              trk_wr;
    logic              seg_wr;
    logic              trk_phase;
    logic              seg_phase;
    logic              end_step;
    logic [STEP_W-1:0] seg_off;
    logic [IDX_W-1:0]  seg_pos;
    logic [IDX_W-1:0]  trk_pos;
    pt_t               in_pt;
    pt_t               trk_head;
    pt_t               seg_head;
    pt_t               head_pt;
    tok_t              tok;
    res_t              res;

    assign adv      = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !busy_reg;
    assign in_stall = busy_reg;

    assign trk_ok = trk_cnt_reg < CNT_W'(MAX_TRACKS);
    assign seg_ok = seg_cnt_reg < CNT_W'(MAX_SEGMENTS);
    assign trk_wr = accept && (kind == KIND_TRACK) && trk_ok;
    assign seg_wr = accept && (kind == KIND_SEGMENT) && seg_ok;

    assign in_pt.eta = eta;
    assign in_pt.phi = phi;

    assign trk_phase = issue_reg && (step_reg < STEP_W'(CHAIN_DEPTH));
    assign seg_phase = issue_reg && !trk_phase && (step_reg < STEP_W'(2 * CHAIN_DEPTH));
    assign end_step  = issue_reg && (step_reg == STEP_W'(2 * CHAIN_DEPTH));
    assign seg_off   = step_reg - STEP_W'(CHAIN_DEPTH);
    assign seg_pos   = seg_off[IDX_W-1:0];
    assign trk_pos   = step_reg[IDX_W-1:0];

    always_comb
    begin
        tok.valid = (trk_phase && (step_reg < STEP_W'(trk_cnt_reg)))
                    || (seg_phase && (seg_pos < seg_idx_reg));
        tok.seg   = seg_phase;
        tok.done  = end_step;
        tok.idx   = trk_phase ? trk_pos : seg_pos;
    end

    assign head_pt = trk_phase ? trk_head : seg_head;

    epm_chain u_trk_chain (
        .clk    (clk),
        .shift  (adv && trk_phase),
        .wr     (trk_wr),
        .wr_idx (trk_cnt_reg[IDX_W-1:0]),
        .wr_pt  (in_pt),
        .head   (trk_head)
    );

    epm_chain u_seg_chain (
        .clk    (clk),
        .shift  (adv && seg_phase),
        .wr     (seg_wr),
        .wr_idx (seg_cnt_reg[IDX_W-1:0]),
        .wr_pt  (in_pt),
        .head   (seg_head)
    );

    epm_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .tok    (tok),
        .pt_a   (head_pt),
        .pt_b   (qry_reg),
        .ts_cut (ts_cut_reg),
        .ss_cut (ss_cut_reg),
        .res    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_cut_reg <= CUT_RESET;
            ss_cut_reg <= CUT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TS_CUT: ts_cut_reg <= cfg_data;
                REG_SS_CUT: ss_cut_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            issue_reg   <= 1'b0;
            step_reg    <= '0;
            trk_cnt_reg <= '0;
            seg_cnt_reg <= '0;
        end
        else if (accept)
        begin
            case (kind)
                KIND_CLEAR:
                begin
                    trk_cnt_reg <= '0;
                    seg_cnt_reg <= '0;
                end
                KIND_TRACK:
                begin
                    if (trk_ok)
                    begin
                        trk_cnt_reg <= trk_cnt_reg + 1'b1;
                    end
                end
                KIND_SEGMENT:
                begin
                    if (seg_ok)
                    begin
                        seg_cnt_reg <= seg_cnt_reg + 1'b1;
                        if (trk_cnt_reg != '0)
                        begin
                            busy_reg  <= 1'b1;
                            issue_reg <= 1'b1;
                            step_reg  <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
        else if (adv)
        begin
            if (issue_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (end_step)
                begin
                    issue_reg <= 1'b0;
                end
            end
            if (res.done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_wr)
        begin
            seg_idx_reg <= seg_cnt_reg[IDX_W-1:0];
            qry_reg     <= in_pt;
        end
    end

    // A found pair waits in the pending stage until the next one, or the end of
    // the sweep, tells whether it is the last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (res.done)
            begin
                out_valid_reg  <= pend_valid_reg;
                pend_valid_reg <= 1'b0;
            end
            else if (res.valid)
            begin
                out_valid_reg  <= pend_valid_reg;
                pend_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && (res.done || res.valid))
        begin
            out_kind_reg   <= pend_seg_reg;
            out_first_reg  <= pend_idx_reg;
            out_second_reg <= seg_idx_reg;
            out_msg_reg    <= pend_msg_reg;
            out_last_reg   <= res.done;
        end
        if (adv && res.valid && !res.done)
        begin
            pend_seg_reg <= res.seg;
            pend_idx_reg <= res.idx;
            pend_msg_reg <= res.msg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pair_kind    = out_kind_reg;
    assign first_index  = OUT_IDX_W'(out_first_reg);
    assign second_index = OUT_IDX_W'(out_second_reg);
    assign message_edge = out_msg_reg;
    assign last         = out_last_reg;

endmodule
